// ----- rtl/core/cfpq_pkg.sv -----
// Shared types and constants for the command frame parser queue.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfpq_pkg;

  localparam int unsigned CFPQ_QUEUE_DEPTH = 5;
  localparam logic [7:0]  CFPQ_HEADER_RESET = 8'hAA;

  // input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ADDR,
    PH_CODE,
    PH_DATA
  } cfpq_phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } cfpq_op_t;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] code;
    logic [7:0] value;
  } cfpq_cmd_t;

  // one classified word handed from the parser to the command queue
  typedef struct packed {
    cfpq_op_t  op;
    cfpq_cmd_t cmd;
  } cfpq_work_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfpq_ifs.sv -----
// Valid/ready channel interfaces for the input items and the result items.
// Does not depend on cfpq_pkg; field widths are fixed here.
`timescale 1ns / 1ps
`default_nettype none

interface cfpq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface cfpq_out_if;
  logic       valid;
  logic       ready;
  logic       pop_ok;
  logic [7:0] cmd_address;
  logic [7:0] cmd_code;
  logic [7:0] cmd_value;
  logic       frame_dropped;
  logic [2:0] fill_count;

  modport source (output valid, output pop_ok, output cmd_address, output cmd_code,
                  output cmd_value, output frame_dropped, output fill_count, input ready);
  modport sink   (input valid, input pop_ok, input cmd_address, input cmd_code,
                  input cmd_value, input frame_dropped, input fill_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cfpq_front.sv -----
// Front end: accepts input words, tracks the frame parse phase and classifies
// each word as no-op, push or pop. Depends on cfpq_pkg and cfpq_in_if.
`timescale 1ns / 1ps
`default_nettype none

module cfpq_front
  import cfpq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  cfpq_in_if.sink          in_ch,
  output cfpq_work_t       work,
  output logic             work_valid,
  input  wire logic        work_ready
);

  cfpq_phase_t phase;
  cfpq_phase_t phase_next;
  logic [7:0]  header;
  logic [7:0]  held_address;
  logic [7:0]  held_code;
  logic        accept;
  logic        is_byte;

  assign in_ch.ready = work_ready;
  assign work_valid  = in_ch.valid;
  assign accept      = in_ch.valid && work_ready;
  assign is_byte     = (in_ch.kind == KIND_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      header <= CFPQ_HEADER_RESET;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        header <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte) begin
      if (phase == PH_ADDR) begin
        held_address <= in_ch.rx_byte;
      end
      if (phase == PH_CODE) begin
        held_code <= in_ch.rx_byte;
      end
    end
  end

  // pops leave the phase alone so a frame in progress resumes
  always_comb begin
    phase_next = phase;
    if (accept && is_byte) begin
      case (phase)
        PH_HUNT: begin
          if (in_ch.rx_byte == header) begin
            phase_next = PH_ADDR;
          end
        end
        PH_ADDR: phase_next = PH_CODE;
        PH_CODE: phase_next = PH_DATA;
        PH_DATA: phase_next = PH_HUNT;
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    work.cmd.address = held_address;
    work.cmd.code    = held_code;
    work.cmd.value   = in_ch.rx_byte;
    if (!is_byte) begin
      work.op = OP_POP;
    end else begin
      case (phase)
        PH_DATA: work.op = OP_PUSH;
        default: work.op = OP_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfpq_link_fifo.sv -----
// Two-entry queue of classified words between the parser and the command queue.
// Depends on cfpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfpq_link_fifo
  import cfpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire cfpq_work_t push_work,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output cfpq_work_t      pop_work
);

  cfpq_work_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_work   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_work;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfpq_back.sv -----
// Back end: circular command store with push/pop and the registered result word.
// Depends on cfpq_pkg and cfpq_out_if.
`timescale 1ns / 1ps
`default_nettype none

module cfpq_back
  import cfpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = CFPQ_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       work_valid,
  output logic            work_ready,
  input  wire cfpq_work_t work,
  cfpq_out_if.source      out_ch
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  cfpq_cmd_t        store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid;
  logic             pop_ok;
  cfpq_cmd_t        cmd;
  logic             frame_dropped;
  logic [2:0]       fill_count;
  logic             fire;
  logic             full;
  logic             push_ok;
  logic             pop_hit;
  logic             drop;

  assign work_ready = !out_valid || out_ch.ready;
  assign fire       = work_valid && work_ready;
  assign full       = (count == FULL_CNT);
  assign push_ok    = fire && (work.op == OP_PUSH) && !full;
  assign drop       = (work.op == OP_PUSH) && full;
  assign pop_hit    = (work.op == OP_POP) && (count != '0);

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (fire && pop_hit) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (fire && pop_hit) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store[wr_ptr] <= work.cmd;
    end
  end

  // the result register doubles as the read data register of the store
  always_ff @(posedge clk) begin
    if (fire) begin
      pop_ok        <= pop_hit;
      cmd           <= pop_hit ? store[rd_ptr] : '0;
      frame_dropped <= drop;
      fill_count    <= 3'(count_next);
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.pop_ok        = pop_ok;
  assign out_ch.cmd_address   = cmd.address;
  assign out_ch.cmd_code      = cmd.code;
  assign out_ch.cmd_value     = cmd.value;
  assign out_ch.frame_dropped = frame_dropped;
  assign out_ch.fill_count    = fill_count;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("command count above queue depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr <= LAST_SLOT) && (rd_ptr <= LAST_SLOT))
    else $error("queue pointer out of range");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push_ok |=> count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("accepted push did not grow the count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pop_ok && frame_dropped))
    else $error("result word both pops and drops");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/command_frame_parser_queue_unit.sv -----
// Command frame parser queue, top level.
// Usage:
//   in_ch  carries words of kind and rx_byte; kind 0 is a link byte, kind 1 pops
//          the oldest queued command. A word is taken when valid and ready are high.
//   out_ch returns exactly one result word per input word, in order: pop_ok,
//          cmd_address, cmd_code, cmd_value, frame_dropped and fill_count.
//   cfg_we/cfg_wdata write the header byte; write only while the block is idle.
// From input accept to result valid, a word is registered in the link queue, then
// in the result register, into which the command store read lands. The block takes
// one word per cycle while out_ch does not stall.
// Reset clears the parse phase (hunting), the queue pointers and count, and sets
// the header byte to 0xAA; store contents are not cleared.
// When out_ch stalls, the back end holds its result, the two-entry link queue
// fills, and then in_ch.ready drops until the receiver takes a word again.
// Depends on cfpq_pkg, cfpq_ifs, cfpq_front, cfpq_link_fifo and cfpq_back.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser_queue_unit
  import cfpq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = CFPQ_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  cfpq_in_if.sink         in_ch,
  cfpq_out_if.source      out_ch
);

  cfpq_work_t front_work;
  logic       front_valid;
  logic       front_ready;
  cfpq_work_t back_work;
  logic       back_valid;
  logic       back_ready;

  cfpq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .work       (front_work),
    .work_valid (front_valid),
    .work_ready (front_ready)
  );

  cfpq_link_fifo u_link (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_work  (front_work),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_work   (back_work)
  );

  cfpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (back_valid),
    .work_ready (back_ready),
    .work       (back_work),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/cfpq_result_checker.sv -----
// Result checker for the command frame parser queue: watches both channels and
// the header register port, predicts every result word and compares in order.
// Depends on cfpq_pkg and the channel interfaces in cfpq_ifs.
`timescale 1ns / 1ps

module cfpq_result_checker
  import cfpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  cfpq_in_if              in_mon,
  cfpq_out_if             out_mon,
  output int unsigned     fail_count,
  output int unsigned     outstanding
);

  typedef struct packed {
    logic       pop_ok;
    cfpq_cmd_t  cmd;
    logic       frame_dropped;
    logic [2:0] fill_count;
  } cfpq_result_t;

  logic [7:0]   header_q;
  cfpq_phase_t  phase_q;
  logic [7:0]   addr_q;
  logic [7:0]   code_q;
  cfpq_cmd_t    store_q [CFPQ_QUEUE_DEPTH];
  int unsigned  wr_idx;
  int unsigned  rd_idx;
  int unsigned  count_q;
  cfpq_result_t pending_q [$];
  int unsigned  mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= CFPQ_QUEUE_DEPTH) ? 0 : p + 1;
  endfunction

  // Advance the parser and the command queue by one word, return its result.
  function automatic cfpq_result_t parse_and_queue(logic k, logic [7:0] b);
    cfpq_result_t r;
    r = '0;
    if (k == KIND_BYTE) begin
      case (phase_q)
        PH_HUNT: if (b == header_q) phase_q = PH_ADDR;
        PH_ADDR: begin
          addr_q  = b;
          phase_q = PH_CODE;
        end
        PH_CODE: begin
          code_q  = b;
          phase_q = PH_DATA;
        end
        default: begin
          if (count_q >= CFPQ_QUEUE_DEPTH) begin
            r.frame_dropped = 1'b1;
          end else begin
            store_q[wr_idx] = '{address: addr_q, code: code_q, value: b};
            wr_idx  = next_slot(wr_idx);
            count_q = count_q + 1;
          end
          phase_q = PH_HUNT;
        end
      endcase
    end else if (count_q != 0) begin
      r.pop_ok = 1'b1;
      r.cmd    = store_q[rd_idx];
      rd_idx   = next_slot(rd_idx);
      count_q  = count_q - 1;
    end
    r.fill_count = 3'(count_q);
    return r;
  endfunction

  function automatic string show(cfpq_result_t r);
    return $sformatf("ok=%0d addr=%02h code=%02h value=%02h drop=%0d fill=%0d",
                     r.pop_ok, r.cmd.address, r.cmd.code, r.cmd.value,
                     r.frame_dropped, r.fill_count);
  endfunction

  always @(posedge clk) begin
    cfpq_result_t want;
    cfpq_result_t got;
    if (rst) begin
      header_q = CFPQ_HEADER_RESET;
      phase_q  = PH_HUNT;
      addr_q   = '0;
      code_q   = '0;
      wr_idx   = 0;
      rd_idx   = 0;
      count_q  = 0;
      pending_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        pending_q.push_back(parse_and_queue(in_mon.kind, in_mon.rx_byte));
      // header takes effect for words accepted after this edge
      if (cfg_we) header_q = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        got = '{pop_ok: out_mon.pop_ok,
                cmd: '{address: out_mon.cmd_address, code: out_mon.cmd_code,
                       value: out_mon.cmd_value},
                frame_dropped: out_mon.frame_dropped,
                fill_count: out_mon.fill_count};
        if (pending_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result word: %s", show(got));
          mismatches++;
        end else begin
          want = pending_q.pop_front();
          if (got.pop_ok !== want.pop_ok || got.cmd.address !== want.cmd.address ||
              got.cmd.code !== want.cmd.code || got.cmd.value !== want.cmd.value ||
              got.frame_dropped !== want.frame_dropped ||
              got.fill_count !== want.fill_count) begin
            if (mismatches < 10)
              $display("result mismatch: expected %s, got %s", show(want), show(got));
            mismatches++;
          end
        end
      end
    end
    outstanding <= pending_q.size();
    fail_count  <= mismatches;
  end

endmodule

// ----- tb/command_frame_parser_queue_unit_tb.sv -----
// Testbench top for the command frame parser queue: drives link bytes, pops and
// header writes with random idling on both channels and gives the verdict.
// Depends on cfpq_pkg, cfpq_ifs, the block and cfpq_result_checker.
`timescale 1ns / 1ps

module command_frame_parser_queue_unit_tb;
  import cfpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        steady;
  logic [7:0]  header_now;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;

  cfpq_in_if  in_ch ();
  cfpq_out_if out_ch ();

  command_frame_parser_queue_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cfpq_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("command_frame_parser_queue_unit_tb: done, errors");
    $finish;
  end

  // Receiver: stall a random number of cycles before taking each result word.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_word(input logic k, input logic [7:0] b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 39) == 0) steady <= !steady;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    words_sent++;
  endtask

  // Hold the input and wait until every predicted result word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_header(input logic [7:0] v);
    drain_results();
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    header_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] frame_byte();
    return ($urandom_range(0, 7) == 0) ? header_now : 8'($urandom);
  endfunction

  // Header plus up to three body bytes, with pops mixed in between.
  task automatic send_frame(input int unsigned body_len, input int unsigned pop_pct);
    send_word(KIND_BYTE, header_now);
    for (int unsigned i = 0; i < body_len; i++) begin
      if ($urandom_range(0, 99) < pop_pct / 3) send_word(KIND_POP, 8'($urandom));
      send_word(KIND_BYTE, frame_byte());
    end
  endtask

  task automatic run_phase(input int unsigned pop_pct, input int unsigned upto);
    int unsigned r;
    while (words_sent < upto) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_word(KIND_BYTE, 8'($urandom));
      else if (r < 13)
        send_frame($urandom_range(0, 2), pop_pct);
      else if (r < 13 + pop_pct)
        send_word(KIND_POP, 8'($urandom));
      else
        send_frame(3, pop_pct);
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    steady        = 1'b0;
    header_now    = CFPQ_HEADER_RESET;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_BYTE;
    in_ch.rx_byte = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pop, discarded noise, extreme frames, header bytes in body
    send_word(KIND_POP, 8'hFF);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_BYTE, header_now);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, header_now);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_BYTE, 8'hFF);
    repeat (4) send_word(KIND_BYTE, header_now);
    // pops inside a frame leave the parse position alone
    send_word(KIND_BYTE, header_now);
    send_word(KIND_BYTE, 8'h12);
    send_word(KIND_POP, 8'h00);
    send_word(KIND_BYTE, 8'h34);
    send_word(KIND_POP, 8'hFF);
    send_word(KIND_BYTE, 8'h56);
    repeat (4) send_word(KIND_POP, 8'($urandom));

    // random: push-heavy phases fill the queue and drop, pop-heavy ones drain it
    run_phase(8, 105);
    write_header(8'h00);
    run_phase(40, 185);
    write_header(8'hFF);
    run_phase(8, 265);
    write_header(8'($urandom));
    run_phase(30, 345);
    write_header(CFPQ_HEADER_RESET);
    run_phase(20, 425);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("command_frame_parser_queue_unit_tb: done, clean");
    else
      $display("command_frame_parser_queue_unit_tb: done, errors");
    $finish;
  end

endmodule
